@@ design/lru_key_value_cache_unit_macros.svh @@
// Assertion helpers for the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define LKVC_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define LKVC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/lkvc_pkg.sv @@
package lkvc_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned CAPACITY_W = 5;

  localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;
  localparam logic [VALUE_W-1:0]    READ_MISS      = '1;

  // action codes
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load_in;   // capture request beat
    logic lookup;    // register key match and slot choice
    logic update;    // apply store writes, read value memory
    logic load_out;  // fill response register
  } cmd_t;

endpackage

@@ design/lkvc_req_if.sv @@
interface lkvc_req_if
  import lkvc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [KEY_W-1:0]   key;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

@@ design/lkvc_rsp_if.sv @@
interface lkvc_rsp_if
  import lkvc_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      hit;
  logic signed [VALUE_W-1:0] read_value;
  logic                      evicted;

  modport source (output valid, hit, read_value, evicted, input ready);
  modport sink   (input valid, hit, read_value, evicted, output ready);
endinterface

@@ design/lkvc_cfg_if.sv @@
interface lkvc_cfg_if
  import lkvc_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CAPACITY_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ design/lkvc_ctrl.sv @@
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_UPDATE,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   out_free;

  // response register can take a beat when empty or draining this cycle
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.load_in  = in_valid_i && in_ready_q;
    cmd_o.lookup   = (state_q == S_MATCH);
    cmd_o.update   = (state_q == S_UPDATE);
    cmd_o.load_out = (state_q == S_RESP) && out_free;
  end

  // sequencer with registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      // a new response beat wins over draining the old one
      if ((state_q == S_RESP) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_MATCH;
            in_ready_q <= 1'b0;
          end
        end
        S_MATCH:  state_q <= S_UPDATE;
        S_UPDATE: state_q <= S_RESP;
        S_RESP: begin
          if (out_free) begin
            in_ready_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

@@ design/lkvc_dp.sv @@
module lkvc_dp
  import lkvc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16,
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cmd_t                      cmd_i,
  input  logic                      cfg_we_i,
  input  logic [CAPACITY_W-1:0]     cfg_data_i,
  input  logic                      action_i,
  input  logic signed [KEY_W-1:0]   key_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      hit_o,
  output logic signed [VALUE_W-1:0] read_value_o,
  output logic                      evicted_o,
  output logic [MAX_ENTRIES-1:0]    entry_valid_o,
  output logic [CNT_W-1:0]          used_count_o
);

  // configuration
  logic [CAPACITY_W-1:0] capacity_q;

  // request beat
  logic               action_q;
  logic [KEY_W-1:0]   key_q;
  logic [VALUE_W-1:0] value_q;

  // entry store
  logic [KEY_W-1:0]   keys_q  [MAX_ENTRIES];
  logic [VALUE_W-1:0] val_mem [MAX_ENTRIES];
  logic [IDX_W-1:0]   age_q   [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_q;
  logic [CNT_W-1:0]   used_q;

  // lookup results
  logic             hit_q, evict_q, promote_q, insert_q, key_wr_q;
  logic [IDX_W-1:0] idx_q, old_age_q;
  logic [VALUE_W-1:0] rd_q;

  // response register
  logic               rsp_hit_q, rsp_evict_q;
  logic [VALUE_W-1:0] rsp_value_q;

  // match-stage logic
  logic             found;
  logic [IDX_W-1:0] found_idx, found_age, free_idx, lru_idx, lru_age;
  logic [CNT_W-1:0] cap_eff;
  logic             room, is_set;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      action_q <= action_i;
      key_q    <= key_i;
      value_q  <= value_i;
    end
  end

  // effective capacity: zero counts as one, saturate at store depth
  always_comb begin
    if (capacity_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (int'(capacity_q) > int'(MAX_ENTRIES)) begin
      cap_eff = CNT_W'(MAX_ENTRIES);
    end else begin
      cap_eff = CNT_W'(capacity_q);
    end
  end

  assign room    = (used_q < cap_eff);
  assign is_set  = (action_q == ACT_SET);
  // ages of valid entries are a permutation of 0..used-1, so LRU has age used-1
  assign lru_age = IDX_W'(used_q - CNT_W'(1));

  // parallel key compare, lowest-slot priority on every search
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    found_age = '0;
    free_idx  = '0;
    lru_idx   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (keys_q[i] == key_q)) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
        found_age = age_q[i];
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
      if (valid_q[i] && (age_q[i] == lru_age)) begin
        lru_idx = IDX_W'(i);
      end
    end
  end

  // register the decision for the update cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      hit_q     <= found;
      promote_q <= found || is_set;
      key_wr_q  <= is_set && !found;
      insert_q  <= is_set && !found && room;
      evict_q   <= is_set && !found && !room;
      if (found) begin
        idx_q     <= found_idx;
        old_age_q <= found_age;
      end else if (room) begin
        idx_q     <= free_idx;
        old_age_q <= IDX_W'(used_q);  // every valid entry ages
      end else begin
        idx_q     <= lru_idx;
        old_age_q <= lru_age;
      end
    end
  end

  // recency and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      used_q  <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else if (cmd_i.update && promote_q) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (valid_q[i] && (age_q[i] < old_age_q)) begin
          age_q[i] <= age_q[i] + IDX_W'(1);
        end
      end
      age_q[idx_q]   <= '0;
      valid_q[idx_q] <= 1'b1;
      if (insert_q) begin
        used_q <= used_q + CNT_W'(1);
      end
    end
  end

  // key tags
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && key_wr_q) begin
      keys_q[idx_q] <= key_q;
    end
  end

  // value memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.update && is_set) begin
      val_mem[idx_q] <= value_q;
    end
    if (cmd_i.update) begin
      rd_q <= val_mem[idx_q];
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      rsp_hit_q   <= hit_q;
      rsp_evict_q <= evict_q;
      rsp_value_q <= (hit_q && !is_set) ? rd_q : READ_MISS;
    end
  end

  assign hit_o         = rsp_hit_q;
  assign evicted_o     = rsp_evict_q;
  assign read_value_o  = rsp_value_q;
  assign entry_valid_o = valid_q;
  assign used_count_o  = used_q;

endmodule

@@ design/lru_key_value_cache_unit.sv @@
// Fully associative key-value cache with least-recently-used replacement over
// MAX_ENTRIES slots. Each request beat is a get or a set of a 32-bit key; each
// yields exactly one response beat (hit, read value or -1, evicted). Keys are
// matched in parallel against tag flops; values sit in a memory with one write
// and one registered read port. Each item runs through the controller sequence:
// accept, tag match, store update with value read, response load; the next
// request enters only after the response load. The response register lets a new
// request enter while the previous response waits. The store needs no
// clearing pass after reset. The capacity register (reset 16) may be
// written only while the block is idle.
`include "lru_key_value_cache_unit_macros.svh"

module lru_key_value_cache_unit
  import lkvc_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lkvc_req_if.sink   req_i,
  lkvc_rsp_if.source rsp_o,
  lkvc_cfg_if.sink   cfg_i
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  cmd_t                   cmd;
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]       used_count;

  assign cfg_i.ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  lkvc_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_i.valid),
    .cfg_data_i    (cfg_i.data),
    .action_i      (req_i.action),
    .key_i         (req_i.key),
    .value_i       (req_i.value),
    .hit_o         (rsp_o.hit),
    .read_value_o  (rsp_o.read_value),
    .evicted_o     (rsp_o.evicted),
    .entry_valid_o (entry_valid),
    .used_count_o  (used_count)
  );

  // one item in flight: no new beat right after an accept
  `LKVC_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready, "request accepted while busy")

  // occupancy count tracks the valid bits
  `LKVC_ASSERT_IMP(a_used_matches_valid, clk_i, rst_ni, 1'b1, $countones(entry_valid) == int'(used_count), "used count out of step with valid bits")

  // a hit never evicts
  `LKVC_ASSERT_IMP(a_hit_no_evict, clk_i, rst_ni, rsp_o.valid, !(rsp_o.hit && rsp_o.evicted), "eviction reported on a hit")

endmodule

@@ bench/tb_lru_key_value_cache_unit.sv @@
module tb_lru_key_value_cache_unit;
  import lkvc_pkg::*;

  localparam int unsigned SLOTS           = 16;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned ITEMS_PER_PHASE = 235;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned POOL_SIZE       = 20;
  localparam int unsigned NUM_ROWS        = 23;

  typedef struct packed {
    logic                      hit;
    logic signed [VALUE_W-1:0] read_value;
    logic                      evicted;
  } cache_rsp_t;

  // one outstanding response: model prediction plus optional hand-typed value
  typedef struct {
    cache_rsp_t predicted;
    bit         pinned;
    cache_rsp_t pinned_rsp;
  } rsp_expect_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_PINNED, ROW_CAPACITY} row_kind_e;

  // value doubles as the new capacity on a capacity row
  typedef struct {
    row_kind_e                 kind;
    logic                      action;
    logic signed [KEY_W-1:0]   key;
    logic signed [VALUE_W-1:0] value;
    cache_rsp_t                rsp;
  } directed_row_t;

  localparam cache_rsp_t NO_RSP     = '0;
  localparam cache_rsp_t MISS_RSP   = '{hit: 1'b0, read_value: READ_MISS, evicted: 1'b0};
  localparam cache_rsp_t UPDATE_RSP = '{hit: 1'b1, read_value: READ_MISS, evicted: 1'b0};
  localparam cache_rsp_t EVICT_RSP  = '{hit: 1'b0, read_value: READ_MISS, evicted: 1'b1};

  // directed stimulus, run from reset (capacity 16)
  directed_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_PINNED,   ACT_GET, 32'sd0,       32'h1234_5678, MISS_RSP},
    '{ROW_PINNED,   ACT_GET, 32'h8000_0000, 32'hffff_ffff, MISS_RSP},
    '{ROW_PINNED,   ACT_SET, 32'sd0,       32'h7fff_ffff, MISS_RSP},
    '{ROW_PINNED,   ACT_GET, 32'sd0,       32'h0000_0000, '{1'b1, 32'h7fff_ffff, 1'b0}},
    '{ROW_PINNED,   ACT_SET, 32'h8000_0000, 32'h8000_0000, MISS_RSP},
    '{ROW_PINNED,   ACT_GET, 32'h8000_0000, 32'h0000_0000, '{1'b1, 32'h8000_0000, 1'b0}},
    '{ROW_PINNED,   ACT_SET, 32'h7fff_ffff, 32'hffff_ffff, MISS_RSP},
    '{ROW_PINNED,   ACT_GET, 32'h7fff_ffff, 32'h0000_0000, '{1'b1, 32'hffff_ffff, 1'b0}},
    '{ROW_PINNED,   ACT_SET, 32'sd0,       32'h5a5a_5a5a, UPDATE_RSP},
    '{ROW_PINNED,   ACT_GET, 32'hffff_ffff, 32'hdead_beef, MISS_RSP},
    '{ROW_ITEM,     ACT_GET, 32'sd0,       32'h0000_0000, NO_RSP},
    // shrink below the fill level: three live entries, capacity one
    '{ROW_CAPACITY, ACT_GET, 32'sd0,       32'sd1,        NO_RSP},
    '{ROW_PINNED,   ACT_SET, 32'h1234_5678, 32'sd1,        EVICT_RSP},
    '{ROW_PINNED,   ACT_GET, 32'h8000_0000, 32'h0000_0000, MISS_RSP},
    '{ROW_ITEM,     ACT_GET, 32'h7fff_ffff, 32'h0000_0000, NO_RSP},
    '{ROW_ITEM,     ACT_SET, 32'h0bad_0000, 32'sd2,        NO_RSP},
    // zero capacity behaves as one
    '{ROW_CAPACITY, ACT_GET, 32'sd0,       32'sd0,        NO_RSP},
    '{ROW_ITEM,     ACT_SET, 32'ha5a5_a5a5, 32'sd3,        NO_RSP},
    '{ROW_ITEM,     ACT_GET, 32'h1234_5678, 32'h0000_0000, NO_RSP},
    // above the slot count saturates
    '{ROW_CAPACITY, ACT_GET, 32'sd0,       32'sd31,       NO_RSP},
    '{ROW_ITEM,     ACT_SET, 32'sd100,     32'sd100,      NO_RSP},
    '{ROW_ITEM,     ACT_GET, 32'sd100,     32'h0000_0000, NO_RSP},
    '{ROW_CAPACITY, ACT_GET, 32'sd0,       32'sd16,       NO_RSP}
  };

  logic [CAPACITY_W-1:0] phase_caps [NUM_PHASES] = '{
    5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd8, 5'd2, 5'd16
  };

  logic clk;
  logic rst_n;

  lkvc_req_if req_if ();
  lkvc_rsp_if rsp_if ();
  lkvc_cfg_if cfg_if ();

  lru_key_value_cache_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // predictor state
  logic signed [KEY_W-1:0]   slot_key   [SLOTS];
  logic signed [VALUE_W-1:0] slot_value [SLOTS];
  bit                        slot_live  [SLOTS];
  int unsigned               slot_rank  [SLOTS];
  int unsigned               live_count;
  logic [CAPACITY_W-1:0]     capacity_q;

  rsp_expect_t cache_expect_q [$];
  rsp_expect_t pinned_q [$];

  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned req_beats;
  int unsigned hit_count;
  int unsigned evict_count;
  int unsigned sender_idle_pct;
  int unsigned rsp_stall_pct;

  rsp_expect_t seen_head;
  rsp_expect_t new_expect;
  rsp_expect_t new_pin;
  cache_rsp_t  got_rsp;
  bit          any_beat;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // slot s becomes most recent; younger live entries age by one
  function automatic void make_most_recent(int s);
    int unsigned old_rank;
    old_rank = slot_rank[s];
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_live[i] && slot_rank[i] < old_rank) slot_rank[i]++;
    end
    slot_rank[s] = 0;
  endfunction

  function automatic cache_rsp_t predict_access(logic act, logic signed [KEY_W-1:0] k,
                                                logic signed [VALUE_W-1:0] v);
    cache_rsp_t  rsp;
    int unsigned cap;
    int          found;
    int          slot;
    rsp   = MISS_RSP;
    cap   = capacity_q;
    found = -1;
    slot  = -1;
    if (cap == 0) cap = 1;
    if (cap > SLOTS) cap = SLOTS;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_live[i] && slot_key[i] == k) found = i;
    end
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (act == ACT_SET) slot_value[found] = v;
      else rsp.read_value = slot_value[found];
      make_most_recent(found);
    end else if (act == ACT_SET) begin
      if (live_count < cap) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !slot_live[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        // insert with room: everything else ages
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) slot_rank[i]++;
        end
        slot_live[slot] = 1'b1;
        slot_rank[slot] = 0;
        live_count++;
      end else begin
        // replace the oldest live entry
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
        end
        make_most_recent(slot);
        rsp.evicted = 1'b1;
      end
      slot_key[slot]   = k;
      slot_value[slot] = v;
    end
    return rsp;
  endfunction

  function automatic int unsigned report_mismatches(string src, cache_rsp_t want,
                                                    cache_rsp_t got);
    int unsigned n;
    n = 0;
    if (want.hit !== got.hit) begin
      $display("%0t: %s hit expected %0b, got %0b", $time, src, want.hit, got.hit);
      n++;
    end
    if (want.read_value !== got.read_value) begin
      $display("%0t: %s read_value expected %0d (%h), got %0d (%h)", $time, src,
               want.read_value, want.read_value, got.read_value, got.read_value);
      n++;
    end
    if (want.evicted !== got.evicted) begin
      $display("%0t: %s evicted expected %0b, got %0b", $time, src, want.evicted,
               got.evicted);
      n++;
    end
    return n;
  endfunction

  // beat monitor, scoreboard and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      any_beat = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        any_beat = 1'b1;
        got_rsp  = '{rsp_if.hit, rsp_if.read_value, rsp_if.evicted};
        if (cache_expect_q.size() == 0) begin
          $display("%0t: unexpected response beat: expected none, got hit %0b value %0d evicted %0b",
                   $time, got_rsp.hit, got_rsp.read_value, got_rsp.evicted);
          fail_count++;
        end else begin
          seen_head = cache_expect_q.pop_front();
          fail_count += report_mismatches("model", seen_head.predicted, got_rsp);
          if (seen_head.pinned)
            fail_count += report_mismatches("table", seen_head.pinned_rsp, got_rsp);
        end
      end
      if (req_if.valid && req_if.ready) begin
        any_beat = 1'b1;
        new_expect.predicted  = predict_access(req_if.action, req_if.key, req_if.value);
        new_expect.pinned     = 1'b0;
        new_expect.pinned_rsp = NO_RSP;
        if (pinned_q.size() != 0) begin
          new_pin               = pinned_q.pop_front();
          new_expect.pinned     = new_pin.pinned;
          new_expect.pinned_rsp = new_pin.pinned_rsp;
        end
        req_beats++;
        if (new_expect.predicted.hit) hit_count++;
        if (new_expect.predicted.evicted) evict_count++;
        cache_expect_q.push_back(new_expect);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        any_beat   = 1'b1;
        capacity_q = cfg_if.data;
      end
      if (any_beat) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat for %0d cycles, %0d responses outstanding", $time,
                 quiet_cycles, cache_expect_q.size());
        $display("lru_key_value_cache_unit test failed");
        $finish;
      end
    end
  end

  // response side back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  // one request beat; entered and left at a falling edge
  task automatic send_req(logic act, logic signed [KEY_W-1:0] k,
                          logic signed [VALUE_W-1:0] v);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.key    <= k;
    req_if.value  <= v;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // wait until every response is back and the pipe has settled
  task automatic drain_pending();
    req_if.valid <= 1'b0;
    while (cache_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAPACITY_W-1:0] cap);
    drain_pending();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic signed [KEY_W-1:0]   key_pool [POOL_SIZE];
    logic signed [KEY_W-1:0]   k;
    logic signed [VALUE_W-1:0] v;
    int unsigned               eff_cap;
    int unsigned               pool_n;

    rst_n         = 1'b0;
    req_if.valid  = 1'b0;
    req_if.action = ACT_GET;
    req_if.key    = '0;
    req_if.value  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i]   = '0;
      slot_value[i] = '0;
      slot_live[i]  = 1'b0;
      slot_rank[i]  = 0;
    end
    live_count      = 0;
    capacity_q      = CAPACITY_RESET;
    fail_count      = 0;
    quiet_cycles    = 0;
    req_beats       = 0;
    hit_count       = 0;
    evict_count     = 0;
    sender_idle_pct = 0;
    rsp_stall_pct   = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CAPACITY) begin
        write_capacity(directed_rows[r].value[CAPACITY_W-1:0]);
      end else begin
        new_pin.predicted  = NO_RSP;
        new_pin.pinned     = (directed_rows[r].kind == ROW_PINNED);
        new_pin.pinned_rsp = directed_rows[r].rsp;
        pinned_q.push_back(new_pin);
        send_req(directed_rows[r].action, directed_rows[r].key, directed_rows[r].value);
      end
    end

    // random phases: new capacity and flow-control mix each time
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_pending();
      case (p % 4)
        0: begin
          sender_idle_pct = 0;
          rsp_stall_pct   = 0;
        end
        1: begin
          sender_idle_pct = 76;
          rsp_stall_pct   = 0;
        end
        2: begin
          sender_idle_pct = 0;
          rsp_stall_pct   = 76;
        end
        default: begin
          sender_idle_pct = 6;
          rsp_stall_pct   = 6;
        end
      endcase
      write_capacity(phase_caps[p]);
      eff_cap = (phase_caps[p] == 0) ? 1 : (phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p];
      pool_n  = (eff_cap + 4 > POOL_SIZE) ? POOL_SIZE : eff_cap + 4;
      // key pool: a few keys reused often so hits and evictions stay frequent
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'sd0;
      key_pool[3] = -32'sd1;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(pool_n - 1)];
        else k = $urandom;
        case ($urandom_range(15))
          0:       v = 32'h8000_0000;
          1:       v = 32'h7fff_ffff;
          default: v = $urandom;
        endcase
        send_req($urandom_range(1) ? ACT_SET : ACT_GET, k, v);
      end
    end

    drain_pending();
    if (cache_expect_q.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, cache_expect_q.size());
      fail_count++;
    end
    $display("Ran %0d requests: %0d hits, %0d evictions, %0d mismatches.", req_beats,
             hit_count, evict_count, fail_count);
    $display("Capacities 0 to 31 across eight phases, with and without idle and stall.");
    if (fail_count == 0) begin
      $display("lru_key_value_cache_unit test passed");
    end else begin
      $display("lru_key_value_cache_unit test failed");
    end
    $finish;
  end

endmodule
